### rtl/core/lfu_pkg.sv
// Shared types and constants for the LFU cache with LRU tie break.
package lfu_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int COUNT_BITS  = 16;
	localparam int KEY_BITS    = 32;
	localparam int DATA_BITS   = 31;
	localparam int CAP_BITS    = 5;
	localparam int IDX_BITS    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int RANK_BITS   = IDX_BITS;
	localparam int OCC_BITS    = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_BITS    = (OCC_BITS > CAP_BITS) ? OCC_BITS : CAP_BITS;

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic                 cmd;
		logic [KEY_BITS-1:0]  key;
		logic [DATA_BITS-1:0] value;
	} req_t;

	typedef struct packed {
		logic                 found;
		logic [DATA_BITS-1:0] read_value;
		logic                 evicted;
		logic [KEY_BITS-1:0]  evicted_key;
	} rsp_t;

	// One stored entry: key, value and use count
	typedef struct packed {
		logic [KEY_BITS-1:0]   key;
		logic [DATA_BITS-1:0]  data;
		logic [COUNT_BITS-1:0] count;
	} entry_t;

	localparam int ENTRY_BITS = $bits(entry_t);

	// What one scan over the store found
	typedef struct packed {
		logic                  hit;
		logic [IDX_BITS-1:0]   hit_idx;
		logic [RANK_BITS-1:0]  hit_rank;
		logic [COUNT_BITS-1:0] hit_count;
		logic [DATA_BITS-1:0]  hit_data;
		logic                  vic;
		logic [IDX_BITS-1:0]   vic_idx;
		logic [RANK_BITS-1:0]  vic_rank;
		logic [KEY_BITS-1:0]   vic_key;
		logic [IDX_BITS-1:0]   free_idx;
	} scan_res_t;

endpackage

### rtl/core/lfu_cache_lru_tiebreak.sv
// Top level of the LFU key-value cache with LRU tie break.
// Each request is accepted, then every entry is streamed out of the entry RAM
// through its single read port, then a commit writes the touched or inserted
// entry back and updates all recency ranks at once. A new request is accepted
// only after that commit. The result sits in an output register, so the next
// request is accepted while it waits; the commit waits while the register
// still holds an untaken result. Capacity values above MAX_ENTRIES act as
// MAX_ENTRIES; capacity 0 ignores puts. Valid bits clear at reset; no
// clearing pass is needed.
module lfu_cache_lru_tiebreak (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  lfu_pkg::req_t                req,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output lfu_pkg::rsp_t                rsp,
	input  logic                         cfg_we,
	input  logic [lfu_pkg::CAP_BITS-1:0] cfg_wdata
);
	import lfu_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]           state_q;
	logic [IDX_BITS:0]    ix_q;
	logic                 vld_s1;
	logic [IDX_BITS-1:0]  idx_s1;
	req_t                 req_q;
	logic [CAP_BITS-1:0]  capacity_q;
	logic [OCC_BITS-1:0]  occ_q;
	logic [MAX_ENTRIES-1:0] valid_q;
	logic [RANK_BITS-1:0] rank_q [MAX_ENTRIES];
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	logic                 accept;
	logic                 issue;
	logic                 commit;
	entry_t               rd_ent;
	entry_t               wr_ent;
	logic                 wr_en;
	logic [IDX_BITS-1:0]  wr_idx;
	scan_res_t            scan;
	logic [CMP_BITS-1:0]  cap_eff;
	logic                 do_touch;
	logic                 do_insert;
	logic                 do_evict;
	logic                 bump_all;
	logic [RANK_BITS-1:0] thr;
	logic [COUNT_BITS-1:0] count_inc;

	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign issue     = (state_q == ST_SCAN) && (ix_q < (IDX_BITS + 1)'(MAX_ENTRIES));
	assign commit    = (state_q == ST_DONE) && (!rsp_valid_q || rsp_ready);

	// Sequence one request: scan all entries, then commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ix_q    <= '0;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1 <= issue;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
						ix_q    <= '0;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						ix_q <= ix_q + 1'b1;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the request and the read index of the stage after the RAM
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		idx_s1 <= ix_q[IDX_BITS-1:0];
	end

	lfu_ram #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(MAX_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_idx),
		.wdata(wr_ent),
		.raddr(ix_q[IDX_BITS-1:0]),
		.rdata(rd_ent)
	);

	lfu_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.vld_s1   (vld_s1),
		.idx_s1   (idx_s1),
		.ent      (rd_ent),
		.ent_valid(valid_q[idx_s1]),
		.ent_rank (rank_q[idx_s1]),
		.key      (req_q.key),
		.res      (scan)
	);

	// Decide what the request does to the store
	always_comb begin
		if (CMP_BITS'(capacity_q) > CMP_BITS'(MAX_ENTRIES)) begin
			cap_eff = CMP_BITS'(MAX_ENTRIES);
		end else begin
			cap_eff = CMP_BITS'(capacity_q);
		end
		do_touch  = scan.hit && ((req_q.cmd == CMD_GET) || (cap_eff != '0));
		do_insert = !scan.hit && (req_q.cmd == CMD_PUT) && (cap_eff != '0);
		do_evict  = do_insert && (CMP_BITS'(occ_q) >= cap_eff) && scan.vic;
		bump_all  = do_insert && !do_evict;
		thr       = do_touch ? scan.hit_rank : scan.vic_rank;
		count_inc = (scan.hit_count == COUNT_MAX) ? scan.hit_count
			: scan.hit_count + 1'b1;
		wr_en     = commit && (do_touch || do_insert);
		if (do_touch) begin
			wr_idx      = scan.hit_idx;
			wr_ent.key  = req_q.key;
			wr_ent.data = (req_q.cmd == CMD_PUT) ? req_q.value : scan.hit_data;
			wr_ent.count = count_inc;
		end else begin
			wr_idx       = do_evict ? scan.vic_idx : scan.free_idx;
			wr_ent.key   = req_q.key;
			wr_ent.data  = req_q.value;
			wr_ent.count = COUNT_BITS'(1);
		end
	end

	// Valid bits, occupancy and capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			occ_q      <= '0;
			capacity_q <= CAP_BITS'(16);
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			if (commit && do_insert) begin
				valid_q[wr_idx] <= 1'b1;
				if (!do_evict) begin
					occ_q <= occ_q + 1'b1;
				end
			end
		end
	end

	// Age entries newer than the hit or victim (all on a free insert), slot to front
	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int j = 0; j < MAX_ENTRIES; j++) begin
				if (valid_q[j] && (bump_all || (rank_q[j] < thr))) begin
					rank_q[j] <= rank_q[j] + 1'b1;
				end
			end
			rank_q[wr_idx] <= '0;
		end
	end

	// Output register: hold the item until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_q.found       <= scan.hit;
			rsp_q.read_value  <= scan.hit ? scan.hit_data : '0;
			rsp_q.evicted     <= do_evict;
			rsp_q.evicted_key <= do_evict ? scan.vic_key : '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### rtl/core/lfu_ram.sv
// Generic simple dual-port RAM with registered read.
module lfu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/core/lfu_scan.sv
// Scan tracker: finds the hit, the eviction victim and the first free slot.
module lfu_scan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          vld_s1,
	input  logic [lfu_pkg::IDX_BITS-1:0]  idx_s1,
	input  lfu_pkg::entry_t               ent,
	input  logic                          ent_valid,
	input  logic [lfu_pkg::RANK_BITS-1:0] ent_rank,
	input  logic [lfu_pkg::KEY_BITS-1:0]  key,
	output lfu_pkg::scan_res_t            res
);
	import lfu_pkg::*;

	logic                  hit_q;
	logic                  vic_q;
	logic                  free_q;
	logic [IDX_BITS-1:0]   hit_idx_q;
	logic [RANK_BITS-1:0]  hit_rank_q;
	logic [COUNT_BITS-1:0] hit_count_q;
	logic [DATA_BITS-1:0]  hit_data_q;
	logic [IDX_BITS-1:0]   vic_idx_q;
	logic [RANK_BITS-1:0]  vic_rank_q;
	logic [KEY_BITS-1:0]   vic_key_q;
	logic [COUNT_BITS-1:0] vic_count_q;
	logic [IDX_BITS-1:0]   free_idx_q;
	logic                  is_hit;
	logic                  is_vic;
	logic                  is_free;

	// Lowest count wins, then the oldest rank
	always_comb begin
		is_hit  = vld_s1 && ent_valid && (ent.key == key) && !hit_q;
		is_vic  = vld_s1 && ent_valid &&
			(!vic_q || (ent.count < vic_count_q) ||
			((ent.count == vic_count_q) && (ent_rank > vic_rank_q)));
		is_free = vld_s1 && !ent_valid && !free_q;
	end

	// Clear the flags at start, capture candidates as entries stream by
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			vic_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (start) begin
			hit_q  <= 1'b0;
			vic_q  <= 1'b0;
			free_q <= 1'b0;
		end else begin
			if (is_hit) begin
				hit_q <= 1'b1;
			end
			if (is_vic) begin
				vic_q <= 1'b1;
			end
			if (is_free) begin
				free_q <= 1'b1;
			end
		end
	end

	// Payload of the candidates
	always_ff @(posedge clk) begin
		if (is_hit) begin
			hit_idx_q   <= idx_s1;
			hit_rank_q  <= ent_rank;
			hit_count_q <= ent.count;
			hit_data_q  <= ent.data;
		end
		if (is_vic) begin
			vic_idx_q   <= idx_s1;
			vic_rank_q  <= ent_rank;
			vic_key_q   <= ent.key;
			vic_count_q <= ent.count;
		end
		if (is_free) begin
			free_idx_q <= idx_s1;
		end
	end

	always_comb begin
		res.hit       = hit_q;
		res.hit_idx   = hit_idx_q;
		res.hit_rank  = hit_rank_q;
		res.hit_count = hit_count_q;
		res.hit_data  = hit_data_q;
		res.vic       = vic_q;
		res.vic_idx   = vic_idx_q;
		res.vic_rank  = vic_rank_q;
		res.vic_key   = vic_key_q;
		res.free_idx  = free_idx_q;
	end

endmodule

### rtl/core/lfu_checker.sv
// Port-level checks for the LFU cache, bound to the top level.
module lfu_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input lfu_pkg::req_t                req,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input lfu_pkg::rsp_t                rsp,
	input logic                         cfg_we,
	input logic [lfu_pkg::CAP_BITS-1:0] cfg_wdata
);
	import lfu_pkg::*;

	// A stalled result item holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result item changed while stalled");

	// One request at a time: no accept right after an accept
	a_one_at_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while one is in work");

	// No eviction means no evicted key
	a_evk_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.evicted |-> rsp.evicted_key == '0)
		else $error("evicted key set without an eviction");

	// A miss reads zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.found |-> rsp.read_value == '0)
		else $error("read value set on a miss");

	// A hit never evicts
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.found |-> !rsp.evicted)
		else $error("eviction reported on a hit");

endmodule

bind lfu_cache_lru_tiebreak lfu_checker u_lfu_checker (.*);

### bench/tb_lfu_cache_lru_tiebreak.sv
// Self-checking testbench for the LFU key-value cache with LRU tie break.
module tb_lfu_cache_lru_tiebreak;
	import lfu_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_WAIT  = MAX_ENTRIES + 8;
	localparam int POOL_SIZE   = 20;
	localparam int EXP_DEPTH   = 8;
	localparam int HOT_GETS    = 24;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_ready;
	req_t                req = '0;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	rsp_t                rsp;
	logic                cfg_we = 1'b0;
	logic [CAP_BITS-1:0] cfg_wdata = '0;

	// Shadow copy of the cache contents
	logic                  shadow_valid [MAX_ENTRIES] = '{default: 1'b0};
	logic [KEY_BITS-1:0]   shadow_key   [MAX_ENTRIES];
	logic [DATA_BITS-1:0]  shadow_data  [MAX_ENTRIES];
	logic [COUNT_BITS-1:0] shadow_count [MAX_ENTRIES];
	int                    shadow_rank  [MAX_ENTRIES];
	int                    shadow_occ = 0;
	logic [CAP_BITS-1:0]   shadow_cap = 5'd16;

	// Expected responses in order, as a ring with running write and read counts
	rsp_t exp_buf [EXP_DEPTH];
	int   exp_wr = 0;
	int   exp_rd = 0;
	int   mismatches = 0;
	int   quiet_cycles = 0;
	int   send_idle_pct = 0;
	int   rsp_stall_pct = 0;

	lfu_cache_lru_tiebreak dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	// Make an entry most recent and raise its use count up to saturation
	function automatic void promote_entry(int idx);
		int j;
		for (j = 0; j < MAX_ENTRIES; j++) begin
			if (shadow_valid[j] && shadow_rank[j] < shadow_rank[idx])
				shadow_rank[j]++;
		end
		shadow_rank[idx] = 0;
		if (shadow_count[idx] != COUNT_MAX)
			shadow_count[idx]++;
	endfunction

	// Apply one request to the shadow cache and return its response
	function automatic rsp_t cache_access(req_t r);
		rsp_t o;
		int   i;
		int   hit;
		int   slot;
		int   victim;
		int   vrank;
		int   cap;
		o = '0;
		hit = -1;
		slot = -1;
		victim = -1;
		cap = (shadow_cap > MAX_ENTRIES) ? MAX_ENTRIES : int'(shadow_cap);
		for (i = 0; i < MAX_ENTRIES; i++) begin
			if (hit < 0 && shadow_valid[i] && shadow_key[i] == r.key)
				hit = i;
		end
		if (hit >= 0) begin
			o.found = 1'b1;
			o.read_value = shadow_data[hit];
		end
		if (r.cmd == CMD_GET) begin
			if (hit >= 0)
				promote_entry(hit);
		end else if (cap != 0) begin
			if (hit >= 0) begin
				promote_entry(hit);
				shadow_data[hit] = r.value;
			end else begin
				// Full: drop the least used entry, oldest first on a tie
				if (shadow_occ >= cap) begin
					for (i = 0; i < MAX_ENTRIES; i++) begin
						if (shadow_valid[i] && (victim < 0 ||
						    shadow_count[i] < shadow_count[victim] ||
						    (shadow_count[i] == shadow_count[victim] &&
						     shadow_rank[i] > shadow_rank[victim])))
							victim = i;
					end
					if (victim >= 0) begin
						o.evicted = 1'b1;
						o.evicted_key = shadow_key[victim];
						vrank = shadow_rank[victim];
						shadow_valid[victim] = 1'b0;
						for (i = 0; i < MAX_ENTRIES; i++) begin
							if (shadow_valid[i] && shadow_rank[i] > vrank)
								shadow_rank[i]--;
						end
						shadow_occ--;
						slot = victim;
					end
				end
				for (i = 0; i < MAX_ENTRIES; i++) begin
					if (slot < 0 && !shadow_valid[i])
						slot = i;
				end
				// Insert as most recent with use count one
				if (slot >= 0) begin
					for (i = 0; i < MAX_ENTRIES; i++) begin
						if (shadow_valid[i])
							shadow_rank[i]++;
					end
					shadow_valid[slot] = 1'b1;
					shadow_key[slot] = r.key;
					shadow_data[slot] = r.value;
					shadow_count[slot] = COUNT_BITS'(1);
					shadow_rank[slot] = 0;
					shadow_occ++;
				end
			end
		end
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
		mismatches++;
	endtask

	// Send one request item, idling first at the current sender rate
	task automatic send_req(input logic cmd, input logic [KEY_BITS-1:0] key,
			input logic [DATA_BITS-1:0] value);
		req_t item;
		item.cmd = cmd;
		item.key = key;
		item.value = value;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do
			@(posedge clk);
		while (!req_ready);
		exp_buf[exp_wr % EXP_DEPTH] = cache_access(item);
		exp_wr++;
	endtask

	// Wait until the block is idle, then write the capacity register
	task automatic write_capacity(input logic [CAP_BITS-1:0] cap);
		req_valid <= 1'b0;
		while (exp_wr != exp_rd)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_cap = cap;
	endtask

	// Hits, misses and overwrites at the field extremes
	task automatic test_basic_access();
		write_capacity(5'd16);
		send_req(CMD_GET, 32'h0000_0000, 31'h0);
		send_req(CMD_PUT, 32'h0000_0000, 31'h0);
		send_req(CMD_PUT, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
		send_req(CMD_GET, 32'hFFFF_FFFF, 31'h0);
		send_req(CMD_PUT, 32'h0000_0000, 31'h5555_5555);
		send_req(CMD_GET, 32'h0000_0000, 31'h7FFF_FFFF);
	endtask

	// Victim choice among equal counts: least recent first
	task automatic test_eviction_order();
		write_capacity(5'd2);
		send_req(CMD_PUT, 32'hA5A5_A5A5, 31'h2A2A_2A2A);
		send_req(CMD_PUT, 32'h5A5A_5A5A, 31'h1515_1515);
		send_req(CMD_PUT, 32'h0000_0011, 31'h11);
		send_req(CMD_PUT, 32'h0000_0022, 31'h22);
		write_capacity(5'd3);
		send_req(CMD_PUT, 32'h0000_0033, 31'h33);
		send_req(CMD_PUT, 32'h0000_0044, 31'h44);
	endtask

	// Zero capacity: lookups still report, puts change nothing
	task automatic test_zero_capacity();
		write_capacity(5'd0);
		send_req(CMD_PUT, 32'h0000_0055, 31'h55);
		send_req(CMD_PUT, 32'h0000_0000, 31'h1234_5678);
		send_req(CMD_GET, 32'h0000_0000, 31'h0);
		send_req(CMD_GET, 32'h0000_0055, 31'h0);
	endtask

	// Capacity above the store size, and lowered below occupancy
	task automatic test_capacity_limits();
		write_capacity(5'd31);
		send_req(CMD_PUT, 32'h0000_0066, 31'h66);
		write_capacity(5'd17);
		send_req(CMD_PUT, 32'h8000_0000, 31'h4000_0000);
		write_capacity(5'd1);
		send_req(CMD_PUT, 32'h0000_0077, 31'h77);
		send_req(CMD_PUT, 32'h0000_0088, 31'h88);
		send_req(CMD_GET, 32'h0000_0077, 31'h0);
	endtask

	// Raise one key's use count well above the rest, then make it outlive newer keys
	task automatic test_hot_entry();
		int n;
		write_capacity(5'd2);
		send_req(CMD_PUT, 32'hC0DE_0001, 31'h0ABC_DEF0);
		for (n = 0; n < HOT_GETS; n++)
			send_req(CMD_GET, 32'hC0DE_0001, 31'h0);
		for (n = 0; n < 5; n++)
			send_req(CMD_PUT, KEY_BITS'(32'hC0DE_0100 + n), DATA_BITS'(31'h100 + n));
		send_req(CMD_GET, 32'hC0DE_0001, 31'h0);
	endtask

	// Mixed traffic over a small key pool, under each idling pattern
	task automatic test_random_traffic();
		logic [KEY_BITS-1:0]  pool [POOL_SIZE];
		logic [KEY_BITS-1:0]  key;
		logic [DATA_BITS-1:0] value;
		logic [CAP_BITS-1:0]  cap;
		int phase;
		int chunk;
		int n;
		int pick;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
				1: begin send_idle_pct = 72; rsp_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  rsp_stall_pct = 72; end
				default: begin send_idle_pct = 31; rsp_stall_pct = 31; end
			endcase
			for (n = 0; n < POOL_SIZE; n++)
				pool[n] = $urandom;
			for (chunk = 0; chunk < 4; chunk++) begin
				pick = $urandom_range(11);
				case (pick)
					0: cap = 5'd0;
					1: cap = 5'd1;
					2: cap = 5'd16;
					3: cap = 5'd31;
					4: cap = 5'($urandom_range(17, 30));
					default: cap = 5'($urandom_range(2, 12));
				endcase
				write_capacity(cap);
				for (n = 0; n < 100; n++) begin
					pick = $urandom_range(99);
					if (pick < 80)
						key = pool[$urandom_range(POOL_SIZE - 1)];
					else if (pick < 90)
						key = $urandom;
					else if (pick < 95)
						key = '0;
					else
						key = '1;
					pick = $urandom_range(19);
					if (pick == 0)
						value = '0;
					else if (pick == 1)
						value = '1;
					else
						value = DATA_BITS'($urandom);
					send_req($urandom_range(1) ? CMD_PUT : CMD_GET, key, value);
				end
			end
		end
	endtask

	// Receiver: stall at the current rate
	always @(posedge clk)
		rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);

	// Compare each response with the oldest expected one
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (exp_wr == exp_rd) begin
				report_mismatch("unexpected response, evicted_key", rsp.evicted_key, '0);
			end else begin
				want = exp_buf[exp_rd % EXP_DEPTH];
				exp_rd++;
				if (rsp.found !== want.found)
					report_mismatch("found", 32'(rsp.found), 32'(want.found));
				if (rsp.read_value !== want.read_value)
					report_mismatch("read_value", 32'(rsp.read_value), 32'(want.read_value));
				if (rsp.evicted !== want.evicted)
					report_mismatch("evicted", 32'(rsp.evicted), 32'(want.evicted));
				if (rsp.evicted_key !== want.evicted_key)
					report_mismatch("evicted_key", rsp.evicted_key, want.evicted_key);
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("lfu_cache_lru_tiebreak regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_access();
		test_eviction_order();
		test_zero_capacity();
		test_capacity_limits();
		test_hot_entry();
		test_random_traffic();
		req_valid <= 1'b0;
		while (exp_wr != exp_rd)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("lfu_cache_lru_tiebreak regression: pass");
		else
			$display("lfu_cache_lru_tiebreak regression: fail");
		$finish;
	end

endmodule
